// File: rtl/prt_pkg.sv
// shared types and constants for the ping request tracking table
`default_nettype none
package prt_pkg;

	// action codes carried in a request word
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_RECORD = 2'd1;
	localparam logic [1:0] ACT_REPLY  = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	localparam logic [31:0] STALE_LIMIT_RESET = 32'd5000;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] peer_address;
		logic [15:0] sequence_number;
	} req_t;

	typedef struct packed {
		logic       slot_valid;
		logic [3:0] slot_index;
		logic       matched;
	} rsp_t;

	// one stored entry of the table
	typedef struct packed {
		logic [31:0] peer;
		logic [15:0] sequence_number;
		logic [31:0] stamp;
	} entry_t;

endpackage
`default_nettype wire

// File: rtl/prt_entry_ram.sv
// simple dual port entry ram (one write port, one read port) with registered read data
`default_nettype none
module prt_entry_ram #(
	parameter int DEPTH = 16
) (
	input  wire                         clk,
	input  wire                         we,
	input  wire  [$clog2(DEPTH)-1:0]    waddr,
	input  prt_pkg::entry_t             wdata,
	input  wire                         re,
	input  wire  [$clog2(DEPTH)-1:0]    raddr,
	output prt_pkg::entry_t             rdata
);
	import prt_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/prt_scan_ctrl.sv
// scan sequencer: tick counter, done and written flags, entry search
`default_nettype none
module prt_scan_ctrl #(
	parameter int ENTRIES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  prt_pkg::req_t                req,
	input  wire  [31:0]                  stale_limit,
	input  wire                          out_free,
	output logic                         push,
	output prt_pkg::rsp_t                result,
	output logic                         ram_we,
	output logic [$clog2(ENTRIES)-1:0]   ram_waddr,
	output prt_pkg::entry_t              ram_wdata,
	output logic                         ram_re,
	output logic [$clog2(ENTRIES)-1:0]   ram_raddr,
	input  prt_pkg::entry_t              ram_rdata
);
	import prt_pkg::*;

	localparam int IW = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t              state_q;
	req_t                item_q;
	logic [IW:0]         rd_idx_q;
	logic [IW-1:0]       chk_idx_q;
	logic                chk_vld_q;
	logic [31:0]         tick_q;
	logic [ENTRIES-1:0]  done_q;
	logic [ENTRIES-1:0]  written_q;
	rsp_t                result_q;

	entry_t       ent;
	logic         ent_done;
	logic         key_eq;
	logic [31:0]  age;
	logic         hit;
	logic         last;
	logic [7:0]   chk_idx_wide;

	// entries never written read as zero
	always_comb begin
		ent      = written_q[chk_idx_q] ? ram_rdata : '0;
		ent_done = done_q[chk_idx_q];
		key_eq   = (ent.peer == item_q.peer_address) &&
		           (ent.sequence_number == item_q.sequence_number);
		age      = tick_q - ent.stamp;
		case (item_q.action)
			ACT_RECORD: hit = !ent_done || (age > stale_limit);
			ACT_REPLY:  hit = key_eq && !ent_done;
			ACT_QUERY:  hit = key_eq && ent_done;
			default:    hit = 1'b0;
		endcase
		last         = (chk_idx_q == IW'(ENTRIES - 1));
		chk_idx_wide = 8'(chk_idx_q);
	end

	assign req_stall = (state_q != S_IDLE);
	assign push      = (state_q == S_DONE) && out_free;
	assign result    = result_q;

	assign ram_re    = (state_q == S_SCAN) && (rd_idx_q != (IW+1)'(ENTRIES));
	assign ram_raddr = rd_idx_q[IW-1:0];
	assign ram_we    = (state_q == S_SCAN) && chk_vld_q && hit &&
	                   (item_q.action == ACT_RECORD);
	assign ram_waddr = chk_idx_q;
	assign ram_wdata = '{peer: item_q.peer_address,
	                     sequence_number: item_q.sequence_number,
	                     stamp: tick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_idx_q  <= '0;
			chk_idx_q <= '0;
			chk_vld_q <= 1'b0;
			tick_q    <= '0;
			done_q    <= '0;
			written_q <= '0;
			result_q  <= '0;
			item_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q    <= req;
						rd_idx_q  <= '0;
						chk_vld_q <= 1'b0;
						result_q  <= '0;
						if (req.action == ACT_TICK) begin
							tick_q  <= tick_q + 32'd1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// issue the next read while checking the previous one
					chk_vld_q <= ram_re;
					chk_idx_q <= rd_idx_q[IW-1:0];
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + (IW+1)'(1);
					end
					if (chk_vld_q && hit) begin
						state_q <= S_DONE;
						case (item_q.action)
							ACT_RECORD: begin
								written_q[chk_idx_q] <= 1'b1;
								done_q[chk_idx_q]    <= 1'b0;
								result_q <= '{slot_valid: 1'b1,
								              slot_index: chk_idx_wide[3:0],
								              matched: 1'b0};
							end
							ACT_REPLY: begin
								done_q[chk_idx_q] <= 1'b1;
								result_q <= '{slot_valid: 1'b0,
								              slot_index: chk_idx_wide[3:0],
								              matched: 1'b1};
							end
							default: begin
								result_q <= '{slot_valid: 1'b0,
								              slot_index: chk_idx_wide[3:0],
								              matched: 1'b1};
							end
						endcase
					end else if (chk_vld_q && last) begin
						state_q  <= S_DONE;
						result_q <= '0;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/ping_request_tracking_table.sv
// ping request tracking table: tick counter plus a table of outstanding echo requests
// a tick word bumps the tick counter, goes to the done state and loads the output register
// once it is free; record, reply and query words scan the table with one entry ram read
// per scanned entry, ending early at the first hit or after the last entry. one word is in
// work at a time; the next word is taken the cycle after a result loads.
// reset clears the tick counter and all done and written flags at once, stale limit 5000
`default_nettype none
module ping_request_tracking_table #(
	parameter int ENTRIES = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	// request words
	input  wire            req_valid,
	output logic           req_stall,
	input  prt_pkg::req_t  req,
	// response words
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output prt_pkg::rsp_t  rsp,
	// stale limit register write
	input  wire            cfg_valid,
	output logic           cfg_ready,
	input  wire  [31:0]    cfg_data
);
	import prt_pkg::*;

	localparam int IW = $clog2(ENTRIES);

	logic [31:0]    stale_limit_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic           out_free;
	logic           push;
	rsp_t           result;

	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	entry_t         ram_wdata;
	logic           ram_re;
	logic [IW-1:0]  ram_raddr;
	entry_t         ram_rdata;

	// the register port never stalls; the user must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= STALE_LIMIT_RESET;
		end else if (cfg_valid) begin
			stale_limit_q <= cfg_data;
		end
	end

	// output register: free when empty or being taken this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= result;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// search sequencer with the flags and the tick counter
	prt_scan_ctrl #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.stale_limit (stale_limit_q),
		.out_free    (out_free),
		.push        (push),
		.result      (result),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// peer, sequence and stamp of every entry
	prt_entry_ram #(
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
